>>> src/izh_pkg.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: shared package
// Field widths, register indexes, reset values, payload types and the
// Q16.16 rounding and saturation helpers used across the block.
// ----------------------------------------------------------------------------
package izh_pkg;

  localparam int ROW_W     = 5;
  localparam int COL_W     = 4;
  localparam int DATA_W    = 32;
  localparam int DT_W      = 31;
  localparam int CFG_IDX_W = 8;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_BORDER      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_COUPLING = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_BUMP     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP         = 8'd7;

  localparam logic signed [DATA_W-1:0] RST_INPUT_SCALE       = 32'sd5242880;
  localparam logic signed [DATA_W-1:0] RST_OUTPUT_SCALE      = 32'sd1092;
  localparam logic signed [DATA_W-1:0] RST_SPIKE_BORDER      = 32'sd1966080;
  localparam logic signed [DATA_W-1:0] RST_RECOVERY_RATE     = 32'sd1311;
  localparam logic signed [DATA_W-1:0] RST_RECOVERY_COUPLING = 32'sd13107;
  localparam logic signed [DATA_W-1:0] RST_RESET_POTENTIAL   = -32'sd4259840;
  localparam logic signed [DATA_W-1:0] RST_RECOVERY_BUMP     = 32'sd524288;
  localparam logic [DT_W-1:0]          RST_TIME_STEP         = 31'd655;

  // Model constants 0.04, 5 and 140 in Q16.16.
  localparam logic signed [DATA_W-1:0] K_004 = 32'sd2621;
  localparam logic signed [DATA_W-1:0] K_5   = 32'sd327680;
  localparam logic signed [DATA_W-1:0] K_140 = 32'sd9175040;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  // Result queue depth; it bounds the transactions outstanding at once.
  localparam int RES_DEPTH = 32;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W     = RES_PTR_W + 1;

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         column;
    logic signed [DATA_W-1:0] drive;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         out_row;
    logic [COL_W-1:0]         out_column;
    logic signed [DATA_W-1:0] potential_out;
    logic                     spiked;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] input_scale;
    logic signed [DATA_W-1:0] output_scale;
    logic signed [DATA_W-1:0] spike_border;
    logic signed [DATA_W-1:0] recovery_rate;
    logic signed [DATA_W-1:0] recovery_coupling;
    logic signed [DATA_W-1:0] reset_potential;
    logic signed [DATA_W-1:0] recovery_bump;
    logic [DT_W-1:0]          time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] u;
  } state_word_t;

  function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] x);
    if (x > SAT_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      return 32'sh8000_0000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

  // Round half up and drop 16 fraction bits.
  function automatic logic signed [DATA_W-1:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return sat64(s >>> 16);
  endfunction

  // Half-step product: one more bit dropped.
  function automatic logic signed [DATA_W-1:0] rnd17(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd65536;
    return sat64(s >>> 17);
  endfunction

  function automatic logic signed [DATA_W-1:0] neg_sat(input logic signed [DATA_W-1:0] x);
    if (x == 32'sh8000_0000) begin
      return 32'sh7FFF_FFFF;
    end else begin
      return -x;
    end
  endfunction

endpackage

>>> src/izh_stream_if.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface izh_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> src/izh_cfg_regs.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: configuration registers
// Holds the eight model registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module izh_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  izh_stream_if.sink   cfg,
  output izh_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{input_scale:       izh_pkg::RST_INPUT_SCALE,
                output_scale:      izh_pkg::RST_OUTPUT_SCALE,
                spike_border:      izh_pkg::RST_SPIKE_BORDER,
                recovery_rate:     izh_pkg::RST_RECOVERY_RATE,
                recovery_coupling: izh_pkg::RST_RECOVERY_COUPLING,
                reset_potential:   izh_pkg::RST_RESET_POTENTIAL,
                recovery_bump:     izh_pkg::RST_RECOVERY_BUMP,
                time_step:         izh_pkg::RST_TIME_STEP};
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        izh_pkg::REG_INPUT_SCALE:       regs.input_scale       <= cfg.payload.data;
        izh_pkg::REG_OUTPUT_SCALE:      regs.output_scale      <= cfg.payload.data;
        izh_pkg::REG_SPIKE_BORDER:      regs.spike_border      <= cfg.payload.data;
        izh_pkg::REG_RECOVERY_RATE:     regs.recovery_rate     <= cfg.payload.data;
        izh_pkg::REG_RECOVERY_COUPLING: regs.recovery_coupling <= cfg.payload.data;
        izh_pkg::REG_RESET_POTENTIAL:   regs.reset_potential   <= cfg.payload.data;
        izh_pkg::REG_RECOVERY_BUMP:     regs.recovery_bump     <= cfg.payload.data;
        izh_pkg::REG_TIME_STEP:
          regs.time_step <= cfg.payload.data[izh_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/izh_state_mem.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: neuron state memory
// Potential and recovery per neuron in two single-port-write memories with a
// registered read. After reset a sweep writes the initial state to every
// entry, one entry per cycle.
// ----------------------------------------------------------------------------
module izh_state_mem #(
  parameter int                 NEURONS = 512,
  parameter int                 ADDR_W  = 9,
  parameter logic signed [31:0] INIT_V  = '0,
  parameter logic signed [31:0] INIT_U  = '0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ADDR_W-1:0]    rd_addr,
  output izh_pkg::state_word_t rd_word,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  izh_pkg::state_word_t wr_word,
  output logic                 clearing
);

  logic signed [31:0] v_mem [NEURONS];
  logic signed [31:0] u_mem [NEURONS];
  logic [ADDR_W-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(NEURONS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      v_mem[clr_addr] <= INIT_V;
      u_mem[clr_addr] <= INIT_U;
    end else if (wr_en) begin
      v_mem[wr_addr] <= wr_word.v;
      u_mem[wr_addr] <= wr_word.u;
    end
    rd_word <= '{v: v_mem[rd_addr], u: u_mem[rd_addr]};
  end

endmodule

>>> src/izh_half_step.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: Euler half-step
// Five-stage pipeline: v += (dt/2) * (0.04 v^2 + 5 v + 140 - u + I).
// Recovery and drive travel alongside unchanged.
// ----------------------------------------------------------------------------
module izh_half_step (
  input  logic                    clk,
  input  logic [izh_pkg::DT_W-1:0] dt,
  input  logic signed [31:0]      v_in,
  input  logic signed [31:0]      u_in,
  input  logic signed [31:0]      drv_in,
  output logic signed [31:0]      v_out,
  output logic signed [31:0]      u_out,
  output logic signed [31:0]      drv_out
);

  logic signed [63:0] p_vv1, p_5v1, p_t1_2, p_dv4;
  logic signed [31:0] v1, u1, drv1;
  logic signed [31:0] v2, u2, drv2, t2_2;
  logic signed [31:0] v3, u3, drv3, d3;
  logic signed [31:0] v4, u4, drv4;

  always_ff @(posedge clk) begin
    // Square and linear term.
    p_vv1 <= v_in * v_in;
    p_5v1 <= izh_pkg::K_5 * v_in;
    v1    <= v_in;
    u1    <= u_in;
    drv1  <= drv_in;

    t2_2   <= izh_pkg::rnd16(p_5v1);
    p_t1_2 <= izh_pkg::K_004 * izh_pkg::rnd16(p_vv1);
    v2     <= v1;
    u2     <= u1;
    drv2   <= drv1;

    d3   <= izh_pkg::sat64(64'(izh_pkg::rnd16(p_t1_2)) + 64'(t2_2) + 64'(izh_pkg::K_140)
                           - 64'(u2) + 64'(drv2));
    v3   <= v2;
    u3   <= u2;
    drv3 <= drv2;

    p_dv4 <= $signed({1'b0, dt}) * d3;
    v4    <= v3;
    u4    <= u3;
    drv4  <= drv3;

    v_out   <= izh_pkg::sat64(64'(v4) + 64'(izh_pkg::rnd17(p_dv4)));
    u_out   <= u4;
    drv_out <= drv4;
  end

endmodule

>>> src/izh_update_pipe.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: update pipeline
// Reads a neuron's state, runs two half-steps and the recovery update, and
// writes the state back. An incoming neuron that matches one still between
// read and write-back raises the hazard flag and is held off.
// ----------------------------------------------------------------------------
module izh_update_pipe #(
  parameter int HALF_ROWS = 16,
  parameter int COLUMNS   = 16,
  parameter int ADDR_W    = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  izh_pkg::cfg_t         cfg_r,
  input  izh_pkg::in_item_t     item,
  input  logic                  take,
  output logic                  hazard,
  output logic [ADDR_W-1:0]     rd_addr,
  input  izh_pkg::state_word_t  rd_word,
  output logic                  wr_en,
  output logic [ADDR_W-1:0]     wr_addr,
  output izh_pkg::state_word_t  wr_word,
  output logic                  res_valid,
  output izh_pkg::out_item_t    res_item
);

  localparam int LAST     = 18;
  localparam int WR_STAGE = 17;

  typedef struct packed {
    logic                         inrange;
    logic                         neg;
    logic [izh_pkg::ROW_W-1:0]    row;
    logic [izh_pkg::COL_W-1:0]    column;
    logic [ADDR_W-1:0]            idx;
  } ctx_t;

  logic              vld  [0:LAST];
  ctx_t              info [0:LAST];
  logic              in_inrange, in_neg, match_any;
  logic [ADDR_W-1:0] in_idx;

  logic signed [63:0] p_drv0;
  logic signed [31:0] v1, u1, drv1;
  logic signed [31:0] va, ua, drva, vb, ub;
  logic signed [63:0] p_bv12, p_ad14, p_du15, p_out18;
  logic signed [31:0] v12, u12, v13, u13, diff13, v14, u14, v15, u15, v16, u16;
  logic signed [31:0] vfin17, ufin17;
  logic               fire12, fire13, fire14, fire15, fire16, fire17, fire18;

  assign in_inrange = (int'(item.row) < 2 * HALF_ROWS) && (int'(item.column) < COLUMNS);
  assign in_neg     = int'(item.row) >= HALF_ROWS;
  assign in_idx     = ADDR_W'(int'(item.row) * COLUMNS + int'(item.column));
  assign rd_addr    = in_idx;

  always_comb begin
    match_any = 1'b0;
    for (int k = 0; k <= WR_STAGE; k++) begin
      if (vld[k] && info[k].inrange && info[k].idx == in_idx) begin
        match_any = 1'b1;
      end
    end
  end

  assign hazard = in_inrange && match_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[0] <= take;
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    info[0] <= '{inrange: in_inrange, neg: in_neg, row: item.row,
                 column: item.column, idx: in_idx};
    for (int k = 1; k <= LAST; k++) begin
      info[k] <= info[k-1];
    end
    p_drv0 <= cfg_r.input_scale * item.drive;

    // Stage 1: drive rounded, and negated for the lower half of the grid.
    drv1 <= info[0].neg ? izh_pkg::neg_sat(izh_pkg::rnd16(p_drv0))
                        : izh_pkg::rnd16(p_drv0);
    v1   <= rd_word.v;
    u1   <= rd_word.u;

    // Recovery update from the new potential.
    p_bv12 <= cfg_r.recovery_coupling * vb;
    fire12 <= vb > cfg_r.spike_border;
    v12    <= vb;
    u12    <= ub;

    diff13 <= izh_pkg::sat64(64'(izh_pkg::rnd16(p_bv12)) - 64'(u12));
    v13    <= v12;
    u13    <= u12;
    fire13 <= fire12;

    p_ad14 <= cfg_r.recovery_rate * diff13;
    v14    <= v13;
    u14    <= u13;
    fire14 <= fire13;

    p_du15 <= $signed({1'b0, cfg_r.time_step}) * izh_pkg::rnd16(p_ad14);
    v15    <= v14;
    u15    <= u14;
    fire15 <= fire14;

    u16    <= izh_pkg::sat64(64'(u15) + 64'(izh_pkg::rnd16(p_du15)));
    v16    <= v15;
    fire16 <= fire15;

    vfin17 <= fire16 ? cfg_r.reset_potential : v16;
    ufin17 <= fire16 ? izh_pkg::sat64(64'(u16) + 64'(cfg_r.recovery_bump)) : u16;
    fire17 <= fire16;

    p_out18 <= vfin17 * cfg_r.output_scale;
    fire18  <= fire17;
  end

  izh_half_step u_step_a (
    .clk     (clk),
    .dt      (cfg_r.time_step),
    .v_in    (v1),
    .u_in    (u1),
    .drv_in  (drv1),
    .v_out   (va),
    .u_out   (ua),
    .drv_out (drva)
  );

  izh_half_step u_step_b (
    .clk     (clk),
    .dt      (cfg_r.time_step),
    .v_in    (va),
    .u_in    (ua),
    .drv_in  (drva),
    .v_out   (vb),
    .u_out   (ub),
    .drv_out ()
  );

  assign wr_en   = vld[WR_STAGE] && info[WR_STAGE].inrange;
  assign wr_addr = info[WR_STAGE].idx;
  assign wr_word = '{v: vfin17, u: ufin17};

  // Neurons outside the grid return zeros and leave the state untouched.
  assign res_valid = vld[LAST];
  assign res_item  = '{out_row:       info[LAST].row,
                       out_column:    info[LAST].column,
                       potential_out: info[LAST].inrange ? izh_pkg::rnd16(p_out18) : '0,
                       spiked:        info[LAST].inrange && fire18};

endmodule

>>> src/izh_result_fifo.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid: result queue
// Collects finished results and presents them on the output channel, so the
// pipeline keeps running while the consumer stalls.
// ----------------------------------------------------------------------------
module izh_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  izh_pkg::out_item_t  wr_item,
  izh_stream_if.source        result
);

  izh_pkg::out_item_t              store [izh_pkg::RES_DEPTH];
  logic [izh_pkg::RES_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [izh_pkg::CNT_W-1:0]       count;
  logic                            rd_en;

  assign result.valid   = count != '0;
  assign result.payload = store[rd_ptr];
  assign rd_en          = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + izh_pkg::CNT_W'(wr_en) - izh_pkg::CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> count < izh_pkg::CNT_W'(izh_pkg::RES_DEPTH))
    else $error("result queue written while full");
`endif

endmodule

>>> src/izhikevich_neuron_array_update.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid update
// One Euler time step for one neuron of the grid per input transaction, with
// potential and recovery kept per neuron in on-chip memory.
//
//   channel   dir  payload                                   handshake
//   in_item   in   row, column, drive                        valid/ready
//   result    out  out_row, out_column, potential_out,       valid/ready
//                  spiked
//   cfg       in   index, data                               valid/ready
//
// One transaction per cycle is taken while each neuron differs from those still
// between state read and write-back, no sweep runs and under 32 are pending.
// A neuron that is still between state read and write-back holds off a new
// transaction for the same neuron until its write has landed.
// After reset the state memory is swept over all 2*HALF_ROWS*COLUMNS neurons
// (512 by default), during which no input is taken; configuration writes are
// taken. Up to 32 transactions may be outstanding; in_item.ready stays low while
// 32 are, which an output stall can bring about.
// ----------------------------------------------------------------------------
module izhikevich_neuron_array_update #(
  parameter int HALF_ROWS         = 16,
  parameter int COLUMNS           = 16,
  parameter int INITIAL_POTENTIAL = -4259840
) (
  input  logic         clk,
  input  logic         rst,
  izh_stream_if.sink   in_item,
  izh_stream_if.source result,
  izh_stream_if.sink   cfg
);

  localparam int                 NEURONS = 2 * HALF_ROWS * COLUMNS;
  localparam int                 ADDR_W  = $clog2(NEURONS);
  localparam logic signed [31:0] INIT_V  = 32'(INITIAL_POTENTIAL);
  localparam logic signed [31:0] INIT_U  =
    izh_pkg::rnd16(longint'(INITIAL_POTENTIAL) * longint'(izh_pkg::RST_RECOVERY_COUPLING));

  izh_pkg::cfg_t             cfg_r;
  izh_pkg::state_word_t      rd_word, wr_word;
  izh_pkg::out_item_t        res_item;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic                      wr_en, clearing, hazard, take, out_take, res_valid;
  logic [izh_pkg::CNT_W-1:0] pending;

  assign in_item.ready = !clearing && !hazard
                         && (pending < izh_pkg::CNT_W'(izh_pkg::RES_DEPTH));
  assign take          = in_item.valid && in_item.ready;
  assign out_take      = result.valid && result.ready;

  // Transactions accepted whose results have not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + izh_pkg::CNT_W'(take) - izh_pkg::CNT_W'(out_take);
    end
  end

  izh_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_r)
  );

  izh_state_mem #(
    .NEURONS (NEURONS),
    .ADDR_W  (ADDR_W),
    .INIT_V  (INIT_V),
    .INIT_U  (INIT_U)
  ) u_state_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_word  (rd_word),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_word  (wr_word),
    .clearing (clearing)
  );

  izh_update_pipe #(
    .HALF_ROWS (HALF_ROWS),
    .COLUMNS   (COLUMNS),
    .ADDR_W    (ADDR_W)
  ) u_update_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg_r     (cfg_r),
    .item      (in_item.payload),
    .take      (take),
    .hazard    (hazard),
    .rd_addr   (rd_addr),
    .rd_word   (rd_word),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_word   (wr_word),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  izh_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_item (res_item),
    .result  (result)
  );

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= izh_pkg::CNT_W'(izh_pkg::RES_DEPTH))
    else $error("more transactions outstanding than the result queue holds");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> pending == '0)
    else $error("input taken during the state sweep");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !clearing)
    else $error("state write-back during the state sweep");

  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    out_take |-> pending != '0)
    else $error("result delivered with no transaction outstanding");
`endif

endmodule

>>> dv/izhikevich_neuron_array_update_tb.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron grid update: self-checking testbench
// Drives register writes, and neuron transactions with random gaps, under output
// stalls. A Q16.16 predictor of the grid, with its own potential and recovery
// per neuron, works out every result, and the results are checked in order.
// ----------------------------------------------------------------------------
module izhikevich_neuron_array_update_tb;

  localparam int HALF_ROWS         = 16;
  localparam int COLUMNS           = 16;
  localparam int INITIAL_POTENTIAL = -4259840;
  localparam int NEURONS           = 2 * HALF_ROWS * COLUMNS;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOT_NEURONS     = 6;
  localparam int SETTLE_CYCLES   = 30;
  localparam int CYCLE_LIMIT     = 400000;

  localparam logic signed [31:0] Q_POINT04 = 32'sd2621;
  localparam logic signed [31:0] Q_FIVE    = 32'sd327680;
  localparam logic signed [31:0] Q_140     = 32'sd9175040;
  localparam logic signed [31:0] Q_ONE     = 32'sd65536;
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    SET_POWER_ON,
    SET_SILENT,
    SET_FORCED_FIRE,
    SET_SCRAMBLED
  } drill_setting_t;

  typedef struct {
    drill_setting_t                  setting;
    logic [izh_pkg::ROW_W-1:0]       row;
    logic [izh_pkg::COL_W-1:0]       column;
    logic signed [31:0]              drive;
    bit                              typed;
    logic signed [31:0]              want_potential;
    bit                              want_spike;
  } drill_row_t;

  localparam int DRILL_ROWS = 22;

  // Silent rows have a zero output gain and an unreachable border, so every
  // result is zero. Forced-fire rows have the lowest border and an output gain
  // of one, so every fresh neuron fires and returns the reset potential.
  drill_row_t drill_table [DRILL_ROWS] = '{
    '{SET_POWER_ON,    5'd0,  4'd0,  32'sd0,            1'b0, 32'sd0, 1'b0},
    '{SET_POWER_ON,    5'd0,  4'd0,  32'sh0000_4000,    1'b0, 32'sd0, 1'b0},
    '{SET_POWER_ON,    5'd0,  4'd1,  32'sh0000_8000,    1'b0, 32'sd0, 1'b0},
    '{SET_POWER_ON,    5'd17, 4'd2,  32'sh0000_8000,    1'b0, 32'sd0, 1'b0},
    '{SET_POWER_ON,    5'd15, 4'd15, 32'sh0001_0000,    1'b0, 32'sd0, 1'b0},
    '{SET_POWER_ON,    5'd31, 4'd15, -32'sd1,           1'b0, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd1,  4'd0,  Q_MAX,             1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd1,  4'd1,  Q_MIN,             1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd16, 4'd0,  Q_MIN,             1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd16, 4'd1,  Q_MAX,             1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd31, 4'd0,  Q_MIN,             1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd2,  4'd15, -32'sd1,           1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd30, 4'd14, 32'sh5555_5555,    1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd2,  4'd7,  32'shAAAA_AAAA,    1'b1, 32'sd0, 1'b0},
    '{SET_SILENT,      5'd1,  4'd0,  Q_MIN,             1'b1, 32'sd0, 1'b0},
    '{SET_FORCED_FIRE, 5'd4,  4'd0,  Q_MAX,             1'b1, Q_MIN,  1'b1},
    '{SET_FORCED_FIRE, 5'd4,  4'd1,  Q_MIN,             1'b1, Q_MIN,  1'b1},
    '{SET_FORCED_FIRE, 5'd20, 4'd4,  Q_MIN,             1'b1, Q_MIN,  1'b1},
    '{SET_FORCED_FIRE, 5'd20, 4'd5,  Q_MAX,             1'b1, Q_MIN,  1'b1},
    '{SET_FORCED_FIRE, 5'd8,  4'd8,  32'sd0,            1'b1, Q_MIN,  1'b1},
    '{SET_FORCED_FIRE, 5'd24, 4'd9,  -32'sd65536,       1'b1, Q_MIN,  1'b1},
    '{SET_FORCED_FIRE, 5'd12, 4'd12, 32'sd1,            1'b1, Q_MIN,  1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  izh_stream_if #(.payload_t(izh_pkg::in_item_t))  in_item ();
  izh_stream_if #(.payload_t(izh_pkg::out_item_t)) result ();
  izh_stream_if #(.payload_t(izh_pkg::cfg_item_t)) cfg ();

  izhikevich_neuron_array_update #(
    .HALF_ROWS         (HALF_ROWS),
    .COLUMNS           (COLUMNS),
    .INITIAL_POTENTIAL (INITIAL_POTENTIAL)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .result  (result),
    .cfg     (cfg)
  );

  // Predictor state: register copies and per-neuron potential and recovery.
  logic signed [31:0]       gain_in, gain_out, fire_level, rate_a, coupling_b, rest_c, bump_d;
  logic [izh_pkg::DT_W-1:0] step_dt;
  logic signed [31:0]       potential_mem [NEURONS];
  logic signed [31:0]       recovery_mem  [NEURONS];

  izh_pkg::out_item_t expected_updates [$];
  int                 mismatches  = 0;
  int unsigned        cycle_count = 0;
  int                 stall_left  = 0;
  bit                 quiet_sink  = 1'b0;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return Q_MAX;
    if (x < -64'sd2147483648) return Q_MIN;
    return x[31:0];
  endfunction

  // Exact product, rounded half up on the dropped bits, then saturated.
  function automatic logic signed [31:0] fixmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input int shift);
    logic signed [63:0] p;
    p = a * b + (64'sd1 <<< (shift - 1));
    return clamp32(p >>> shift);
  endfunction

  function automatic logic signed [31:0] slope(input logic signed [31:0] v, u, drv);
    logic signed [31:0] sq, quad, lin;
    sq   = fixmul(v, v, 16);
    quad = fixmul(Q_POINT04, sq, 16);
    lin  = fixmul(Q_FIVE, v, 16);
    return clamp32(64'sd0 + quad + lin + Q_140 - u + drv);
  endfunction

  function automatic void power_on_model();
    logic signed [31:0] u0;
    gain_in    = izh_pkg::RST_INPUT_SCALE;
    gain_out   = izh_pkg::RST_OUTPUT_SCALE;
    fire_level = izh_pkg::RST_SPIKE_BORDER;
    rate_a     = izh_pkg::RST_RECOVERY_RATE;
    coupling_b = izh_pkg::RST_RECOVERY_COUPLING;
    rest_c     = izh_pkg::RST_RESET_POTENTIAL;
    bump_d     = izh_pkg::RST_RECOVERY_BUMP;
    step_dt    = izh_pkg::RST_TIME_STEP;
    u0 = fixmul(INITIAL_POTENTIAL, izh_pkg::RST_RECOVERY_COUPLING, 16);
    for (int n = 0; n < NEURONS; n++) begin
      potential_mem[n] = INITIAL_POTENTIAL;
      recovery_mem[n]  = u0;
    end
  endfunction

  function automatic void advance_neuron(input logic [izh_pkg::ROW_W-1:0] r,
                                         input logic [izh_pkg::COL_W-1:0] c,
                                         input logic signed [31:0] drive,
                                         output logic signed [31:0] pot_out,
                                         output logic fired);
    int                 slot;
    logic signed [63:0] dt64;
    logic signed [31:0] drv, v, u, bv, diff, ad;
    pot_out = '0;
    fired   = 1'b0;
    if (int'(r) >= 2 * HALF_ROWS || int'(c) >= COLUMNS) return;
    slot = int'(r) * COLUMNS + int'(c);
    dt64 = {33'd0, step_dt};

    // The lower half of the grid sees the drive inverted.
    drv = fixmul(gain_in, drive, 16);
    if (int'(r) >= HALF_ROWS) drv = clamp32(64'sd0 - drv);

    v = potential_mem[slot];
    u = recovery_mem[slot];
    v = clamp32(64'sd0 + v + fixmul(dt64, slope(v, u, drv), 17));
    v = clamp32(64'sd0 + v + fixmul(dt64, slope(v, u, drv), 17));

    bv   = fixmul(coupling_b, v, 16);
    diff = clamp32(64'sd0 + bv - u);
    ad   = fixmul(rate_a, diff, 16);
    u    = clamp32(64'sd0 + u + fixmul(dt64, ad, 16));

    fired = (v > fire_level);
    if (fired) begin
      v = rest_c;
      u = clamp32(64'sd0 + u + bump_d);
    end
    potential_mem[slot] = v;
    recovery_mem[slot]  = u;
    pot_out = fixmul(v, gain_out, 16);
  endfunction

  // Mostly back to back, some short gaps and now and then a long one.
  function automatic int pick_pause(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_register_value(
      input logic [izh_pkg::CFG_IDX_W-1:0] idx, input bit tame);
    int roll;
    roll = tame ? 0 : $urandom_range(0, 9);
    if (roll >= 8) return $urandom;
    if (roll >= 6) begin
      case ($urandom_range(0, 2))
        0:       return Q_MIN;
        1:       return Q_MAX;
        default: return 32'd0;
      endcase
    end
    case (idx)
      izh_pkg::REG_INPUT_SCALE:       return $urandom_range(0, 160) * 32768;
      izh_pkg::REG_OUTPUT_SCALE:      return $urandom_range(0, 131072);
      izh_pkg::REG_SPIKE_BORDER:      return $urandom_range(10, 40) * 65536;
      izh_pkg::REG_RECOVERY_RATE:     return $urandom_range(655, 6554);
      izh_pkg::REG_RECOVERY_COUPLING: return $urandom_range(6554, 19661);
      izh_pkg::REG_RESET_POTENTIAL:   return -($urandom_range(50, 70) * 65536);
      izh_pkg::REG_RECOVERY_BUMP:     return $urandom_range(0, 8) * 65536;
      default:                        return $urandom_range(655, 65536);
    endcase
  endfunction

  // Leaves cfg.valid high so that writes can follow back to back.
  task automatic write_reg(input logic [izh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    izh_pkg::cfg_item_t word;
    word.index = idx;
    word.data  = data;
    cfg.valid   <= 1'b1;
    cfg.payload <= word;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      izh_pkg::REG_INPUT_SCALE:       gain_in    = data;
      izh_pkg::REG_OUTPUT_SCALE:      gain_out   = data;
      izh_pkg::REG_SPIKE_BORDER:      fire_level = data;
      izh_pkg::REG_RECOVERY_RATE:     rate_a     = data;
      izh_pkg::REG_RECOVERY_COUPLING: coupling_b = data;
      izh_pkg::REG_RESET_POTENTIAL:   rest_c     = data;
      izh_pkg::REG_RECOVERY_BUMP:     bump_d     = data;
      izh_pkg::REG_TIME_STEP:         step_dt    = data[izh_pkg::DT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input drill_setting_t setting, input bit tame);
    case (setting)
      SET_SILENT: begin
        write_reg(izh_pkg::REG_INPUT_SCALE, Q_MAX);
        write_reg(izh_pkg::REG_OUTPUT_SCALE, 32'd0);
        write_reg(izh_pkg::REG_SPIKE_BORDER, Q_MAX);
        write_reg(izh_pkg::REG_RECOVERY_RATE, Q_MIN);
        write_reg(izh_pkg::REG_RECOVERY_COUPLING, Q_MAX);
        write_reg(izh_pkg::REG_RESET_POTENTIAL, Q_MAX);
        write_reg(izh_pkg::REG_RECOVERY_BUMP, Q_MAX);
        write_reg(izh_pkg::REG_TIME_STEP, Q_MAX);
      end
      SET_FORCED_FIRE: begin
        write_reg(izh_pkg::REG_INPUT_SCALE, izh_pkg::RST_INPUT_SCALE);
        write_reg(izh_pkg::REG_OUTPUT_SCALE, Q_ONE);
        write_reg(izh_pkg::REG_SPIKE_BORDER, Q_MIN);
        write_reg(izh_pkg::REG_RECOVERY_RATE, izh_pkg::RST_RECOVERY_RATE);
        write_reg(izh_pkg::REG_RECOVERY_COUPLING, izh_pkg::RST_RECOVERY_COUPLING);
        write_reg(izh_pkg::REG_RESET_POTENTIAL, Q_MIN);
        write_reg(izh_pkg::REG_RECOVERY_BUMP, izh_pkg::RST_RECOVERY_BUMP);
        write_reg(izh_pkg::REG_TIME_STEP, {1'b0, izh_pkg::RST_TIME_STEP});
      end
      default: begin
        write_reg(izh_pkg::REG_INPUT_SCALE,
                  pick_register_value(izh_pkg::REG_INPUT_SCALE, tame));
        write_reg(izh_pkg::REG_OUTPUT_SCALE,
                  pick_register_value(izh_pkg::REG_OUTPUT_SCALE, tame));
        write_reg(izh_pkg::REG_SPIKE_BORDER,
                  pick_register_value(izh_pkg::REG_SPIKE_BORDER, tame));
        write_reg(izh_pkg::REG_RECOVERY_RATE,
                  pick_register_value(izh_pkg::REG_RECOVERY_RATE, tame));
        write_reg(izh_pkg::REG_RECOVERY_COUPLING,
                  pick_register_value(izh_pkg::REG_RECOVERY_COUPLING, tame));
        write_reg(izh_pkg::REG_RESET_POTENTIAL,
                  pick_register_value(izh_pkg::REG_RESET_POTENTIAL, tame));
        write_reg(izh_pkg::REG_RECOVERY_BUMP,
                  pick_register_value(izh_pkg::REG_RECOVERY_BUMP, tame));
        write_reg(izh_pkg::REG_TIME_STEP,
                  pick_register_value(izh_pkg::REG_TIME_STEP, tame));
        // A write past the last register must change nothing.
        write_reg(izh_pkg::CFG_IDX_W'($urandom_range(izh_pkg::REG_TIME_STEP + 1, 255)),
                  $urandom);
      end
    endcase
    cfg.valid <= 1'b0;
  endtask

  // Valid is only lowered when a gap follows, so it stays high between
  // back-to-back transactions.
  task automatic feed_neuron(input logic [izh_pkg::ROW_W-1:0] r,
                             input logic [izh_pkg::COL_W-1:0] c,
                             input logic signed [31:0] drive, input int pause,
                             input bit typed, input logic signed [31:0] want_potential,
                             input bit want_spike);
    izh_pkg::in_item_t  item;
    izh_pkg::out_item_t update;
    logic signed [31:0] pot;
    logic               fired;
    item.row    = r;
    item.column = c;
    item.drive  = drive;
    if (pause > 0) begin
      in_item.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_item.valid   <= 1'b1;
    in_item.payload <= item;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    advance_neuron(r, c, drive, pot, fired);
    update.out_row       = r;
    update.out_column    = c;
    update.potential_out = typed ? want_potential : pot;
    update.spiked        = typed ? want_spike : fired;
    expected_updates.push_back(update);
  endtask

  // Registers change only once the pipeline has emptied and write-back is done.
  task automatic settle();
    in_item.valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet_sink) begin
      result.ready <= 1'b1;
    end else begin
      result.ready <= ($urandom_range(0, 2) != 0);
      stall_left   <= pick_pause(1'b0);
    end
  end

  always @(posedge clk) begin : result_check
    izh_pkg::out_item_t got, want;
    if (!rst && result.valid && result.ready) begin
      got = result.payload;
      if (expected_updates.size() == 0) begin
        $error("unexpected result transaction: row %0d column %0d",
               got.out_row, got.out_column);
        mismatches++;
      end else begin
        want = expected_updates.pop_front();
        if (got.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
          mismatches++;
        end
        if (got.out_column !== want.out_column) begin
          $error("out_column: expected %0d, got %0d", want.out_column, got.out_column);
          mismatches++;
        end
        if (got.potential_out !== want.potential_out) begin
          $error("potential_out: expected %0d, got %0d", want.potential_out, got.potential_out);
          mismatches++;
        end
        if (got.spiked !== want.spiked) begin
          $error("spiked: expected %0d, got %0d", want.spiked, got.spiked);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    drill_setting_t     active;
    logic [8:0]         hot [HOT_NEURONS];
    logic [8:0]         pick;
    logic signed [31:0] drive;
    bit                 calm;
    in_item.valid   = 1'b0;
    in_item.payload = '0;
    cfg.valid       = 1'b0;
    cfg.payload     = '0;
    power_on_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: the first rows run on the reset values of the registers.
    active = SET_POWER_ON;
    foreach (drill_table[k]) begin
      if (drill_table[k].setting != active) begin
        settle();
        active = drill_table[k].setting;
        apply_setting(active, 1'b0);
      end
      feed_neuron(drill_table[k].row, drill_table[k].column, drill_table[k].drive,
                  pick_pause(1'b0), drill_table[k].typed, drill_table[k].want_potential,
                  drill_table[k].want_spike);
    end

    // Random part: a few hot neurons take most transactions so that they are
    // driven repeatedly through to spikes; the rest go anywhere in the grid.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      apply_setting(SET_SCRAMBLED, phase % 2 == 0);
      calm       = (phase % 3 == 1);
      quiet_sink = calm;
      foreach (hot[h]) hot[h] = 9'($urandom_range(0, NEURONS - 1));
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          pick = hot[$urandom_range(0, HOT_NEURONS - 1)];
        end else begin
          pick = 9'($urandom_range(0, NEURONS - 1));
        end
        if ($urandom_range(0, 9) < 7) begin
          drive = int'($urandom_range(0, 40960)) - 8192;
        end else begin
          drive = $urandom;
        end
        feed_neuron(pick[8:4], pick[3:0], drive, pick_pause(calm), 1'b0, 32'sd0, 1'b0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
